>>> rtl/wtsp_pkg.sv
// Shared types and constants for the world-to-screen projection core.
package wtsp_pkg;

    localparam int CFG_W    = 14;  // screen size register width
    localparam int CLIP_W   = 50;  // clip coordinate width, signed Q.16
    localparam int MAG_W    = 50;  // numerator magnitude width
    localparam int K_W      = 17;  // screen size times eight
    localparam int N_W      = 67;  // dividend width, K_W + MAG_W
    localparam int Q_W      = 21;  // quotient bits developed by the divider
    localparam int SCR_W    = 20;  // screen coordinate width, signed Q16.4
    localparam int AXIS_LAT = 25;  // register stages in one axis unit

    localparam logic [1:0] CFG_SCREEN_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_SCREEN_HEIGHT = 2'd1;

    localparam logic REQ_LOAD    = 1'b0;
    localparam logic REQ_PROJECT = 1'b1;

    localparam logic [CFG_W-1:0] RESET_WIDTH  = 14'd1920;
    localparam logic [CFG_W-1:0] RESET_HEIGHT = 14'd1080;

    localparam logic [Q_W-1:0]   DIV_CAP  = 21'h100000;
    localparam logic [SCR_W-1:0] SCR_MAX  = 20'h7FFFF;
    localparam logic [SCR_W-1:0] SCR_MIN  = 20'h80000;

    typedef struct packed {
        logic               req_type;
        logic [3:0]         coef_index;
        logic signed [31:0] coef_value;
        logic signed [31:0] world_x;
        logic signed [31:0] world_y;
        logic signed [31:0] world_z;
    } t_in;

    typedef struct packed {
        logic                    visible;
        logic signed [SCR_W-1:0] screen_x;
        logic signed [SCR_W-1:0] screen_y;
    } t_out;

endpackage

>>> rtl/wtsp_xform.sv
// Matrix store and two-stage matrix-vector transform to clip coordinates.
module wtsp_xform (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_en,
    input  logic                                  i_load,
    input  wtsp_pkg::t_in                         i_in,
    output logic signed [wtsp_pkg::CLIP_W-1:0]    o_clip [4]
);

    logic signed [31:0] r_mat  [16];
    logic signed [63:0] r_prod [4][3];
    logic signed [31:0] r_wterm [4];
    logic signed [wtsp_pkg::CLIP_W-1:0] r_clip [4];
    logic signed [31:0] vec [3];

    assign vec[0] = i_in.world_x;
    assign vec[1] = i_in.world_y;
    assign vec[2] = i_in.world_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 16; i++) r_mat[i] <= '0;
        end else if (i_load) begin
            r_mat[i_in.coef_index] <= i_in.coef_value;
        end
    end

    // Stage 1: twelve products plus the w column (coefficient times one).
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int r = 0; r < 4; r++) begin
                for (int c = 0; c < 3; c++) r_prod[r][c] <= r_mat[r*4+c] * vec[c];
                r_wterm[r] <= r_mat[r*4+3];
            end
        end
    end

    // Stage 2: floor each product to Q.16 (arithmetic shift) and sum the row.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int r = 0; r < 4; r++) begin
                r_clip[r] <= wtsp_pkg::CLIP_W'($signed(r_prod[r][0][63:16]))
                           + wtsp_pkg::CLIP_W'($signed(r_prod[r][1][63:16]))
                           + wtsp_pkg::CLIP_W'($signed(r_prod[r][2][63:16]))
                           + wtsp_pkg::CLIP_W'(r_wterm[r]);
            end
        end
    end

    assign o_clip = r_clip;

endmodule

>>> rtl/wtsp_axis.sv
// One screen axis: scaled multiply, pipelined restoring divide, saturation.
module wtsp_axis (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic [wtsp_pkg::K_W-1:0]           i_k,
    input  logic [wtsp_pkg::MAG_W-1:0]         i_mag,
    input  logic                               i_neg,
    input  logic [wtsp_pkg::MAG_W-1:0]         i_div,
    output logic signed [wtsp_pkg::SCR_W-1:0]  o_coord
);

    localparam int MW = wtsp_pkg::MAG_W;
    localparam int QW = wtsp_pkg::Q_W;
    localparam int NW = wtsp_pkg::N_W;

    logic [48:0]    r_pl;
    logic [34:0]    r_ph;
    logic [NW-1:0]  r_n;
    logic           r_neg1, r_neg2;
    logic [MW-1:0]  r_d1, r_d2;

    logic [MW-1:0]  r_rem [QW+1];
    logic [QW-1:0]  r_low [QW+1];
    logic [QW-1:0]  r_q   [QW+1];
    logic [MW-1:0]  r_d   [QW+1];
    logic           r_neg [QW+1];
    logic           r_ovf [QW+1];
    logic signed [wtsp_pkg::SCR_W-1:0] r_out;

    logic [MW-1:0]  rem0;
    logic [QW-1:0]  qsat;

    // Split the 17x50 product into two partial products.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pl   <= 49'(i_k) * 49'(i_mag[31:0]);
            r_ph   <= 35'(i_k) * 35'(i_mag[MW-1:32]);
            r_neg1 <= i_neg;
            r_d1   <= i_div;
            r_n    <= NW'(r_pl) + {r_ph, 32'b0};
            r_neg2 <= r_neg1;
            r_d2   <= r_d1;
        end
    end

    assign rem0 = MW'(r_n[NW-1:QW]);

    // Quotients of 2^21 or more all saturate; flag them up front.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= rem0;
            r_low[0] <= r_n[QW-1:0];
            r_q[0]   <= '0;
            r_d[0]   <= r_d2;
            r_neg[0] <= r_neg2;
            r_ovf[0] <= (rem0 >= r_d2);
        end
    end

    for (genvar j = 0; j < QW; j++) begin : g_step
        logic [MW:0] trial;
        logic        ge;
        assign trial = {r_rem[j], r_low[j][QW-1]};
        assign ge    = (trial >= {1'b0, r_d[j]});
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j+1] <= ge ? MW'(trial - {1'b0, r_d[j]}) : MW'(trial);
                r_low[j+1] <= {r_low[j][QW-2:0], 1'b0};
                r_q[j+1]   <= {r_q[j][QW-2:0], ge};
                r_d[j+1]   <= r_d[j];
                r_neg[j+1] <= r_neg[j];
                r_ovf[j+1] <= r_ovf[j];
            end
        end
    end

    assign qsat = r_ovf[QW] ? wtsp_pkg::DIV_CAP : r_q[QW];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (!r_neg[QW]) begin
                r_out <= (qsat > QW'(wtsp_pkg::SCR_MAX)) ? wtsp_pkg::SCR_MAX
                                                          : qsat[wtsp_pkg::SCR_W-1:0];
            end else begin
                r_out <= (qsat >= QW'(wtsp_pkg::SCR_MIN)) ? wtsp_pkg::SCR_MIN
                                                           : -qsat[wtsp_pkg::SCR_W-1:0];
            end
        end
    end

    assign o_coord = r_out;

endmodule

>>> rtl/world_to_screen_projection_core.sv
// Top level of the world-to-screen projection core.
// A load transaction (req_type 0) writes one Q16.16 coefficient of the 4x4
// world-to-clip matrix and produces no result; a project transaction (req_type
// 1) transforms (x, y, z, 1), rejects points with clip z or w not positive, and
// maps the rest to Q16.4 screen pixels, saturated. The core takes one
// transaction per cycle unless the output stalls; each projection passes
// through two stages of matrix multiply and row sum, one stage forming the
// axis numerators, then per axis a two-stage scaled multiply, an overflow
// check, a 21-stage restoring divider (one quotient bit per stage) and a
// saturation stage. A stall on the output freezes the whole pipeline. A load
// updates the matrix at once, so a projection right behind it already sees it.
// Write screen_width and screen_height only while the pipeline is empty.
module world_to_screen_projection_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  wtsp_pkg::t_in                 i_in,
    output logic                          o_valid,
    input  logic                          i_ready,
    output wtsp_pkg::t_out                o_out,
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_index,
    input  logic [wtsp_pkg::CFG_W-1:0]    i_cfg_data
);

    localparam int AL  = wtsp_pkg::AXIS_LAT;
    localparam int LAT = AL + 3;
    localparam int CW  = wtsp_pkg::CLIP_W;

    logic                          en, accept;
    logic [wtsp_pkg::CFG_W-1:0]    r_screen_width, r_screen_height;
    logic [LAT-1:0]                r_vld;
    logic [AL:0]                   r_vis;
    logic signed [CW-1:0]          clip [4];
    logic signed [CW-1:0]          num_x, num_y;
    logic [wtsp_pkg::MAG_W-1:0]    r_mag_x, r_mag_y, r_div;
    logic                          r_neg_x, r_neg_y;
    logic signed [wtsp_pkg::SCR_W-1:0] coord_x, coord_y;

    // Advance everything unless a finished result is waiting on the consumer.
    assign en      = !r_vld[LAT-1] || i_ready;
    assign o_ready = en;
    assign accept  = i_valid && en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_width  <= wtsp_pkg::RESET_WIDTH;
            r_screen_height <= wtsp_pkg::RESET_HEIGHT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                wtsp_pkg::CFG_SCREEN_WIDTH:  r_screen_width  <= i_cfg_data;
                wtsp_pkg::CFG_SCREEN_HEIGHT: r_screen_height <= i_cfg_data;
                default: ;  // drop writes to unknown registers
            endcase
        end
    end

    // Valid line: only project transactions enter it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], accept && (i_in.req_type == wtsp_pkg::REQ_PROJECT)};
        end
    end

    wtsp_xform u_xform (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_load  (accept && (i_in.req_type == wtsp_pkg::REQ_LOAD)),
        .i_in    (i_in),
        .o_clip  (clip)
    );

    // Stage 3: numerators cw+cx and cw-cy, their signs and magnitudes.
    assign num_x = clip[3] + clip[0];
    assign num_y = clip[3] - clip[1];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_neg_x <= num_x[CW-1];
            r_neg_y <= num_y[CW-1];
            r_mag_x <= num_x[CW-1] ? wtsp_pkg::MAG_W'(-num_x) : wtsp_pkg::MAG_W'(num_x);
            r_mag_y <= num_y[CW-1] ? wtsp_pkg::MAG_W'(-num_y) : wtsp_pkg::MAG_W'(num_y);
            r_div   <= wtsp_pkg::MAG_W'(clip[3]);
            r_vis   <= {r_vis[AL-1:0], (clip[2] > 0) && (clip[3] > 0)};
        end
    end

    wtsp_axis u_axis_x (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_k     ({r_screen_width, 3'b000}),
        .i_mag   (r_mag_x),
        .i_neg   (r_neg_x),
        .i_div   (r_div),
        .o_coord (coord_x)
    );

    // Screen y flips: numerator is cw - cy.
    wtsp_axis u_axis_y (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_k     ({r_screen_height, 3'b000}),
        .i_mag   (r_mag_y),
        .i_neg   (r_neg_y),
        .i_div   (r_div),
        .o_coord (coord_y)
    );

    // Hidden points report zero coordinates.
    assign o_valid          = r_vld[LAT-1];
    assign o_out.visible    = r_vis[AL];
    assign o_out.screen_x   = r_vis[AL] ? coord_x : '0;
    assign o_out.screen_y   = r_vis[AL] ? coord_y : '0;

endmodule
